// ===== hdl/mer_pkg.sv =====
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types and constants of the midpoint ellipse rasterizer: controller
// states, datapath operation codes, and the command/status structs.
// ----------------------------------------------------------------------------
package mer_pkg;

    // Output point coordinates are 14-bit two's complement
    localparam int OUT_W       = 14;
    localparam int N_POINTS    = 4;
    localparam int OUT_TDATA_W = 2 * N_POINTS * OUT_W;

    // Input item kinds carried on tuser
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    // Controller states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_A,
        ST_SQ_B,
        ST_MUL_A2B,
        ST_INIT_DEC,
        ST_U1,
        ST_U2,
        ST_U3,
        ST_CHECK,
        ST_T_P1,
        ST_T_P2,
        ST_T_Q1,
        ST_T_Q2,
        ST_T_R1,
        ST_T_R2,
        ST_T_FIN,
        ST_FINISH
    } mer_state_t;

    // Datapath operations, one per cycle
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SQ_A,
        OP_SQ_B,
        OP_MUL_A2B,
        OP_INIT_DEC,
        OP_CAPTURE,
        OP_U1,
        OP_U2,
        OP_U3,
        OP_T_P1,
        OP_SQUARE,
        OP_T_Q1,
        OP_T_R1,
        OP_T_FIN,
        OP_EMIT
    } mer_op_t;

    typedef struct packed {
        mer_op_t op;
    } mer_cmd_t;

    typedef struct packed {
        logic active;     // an ellipse is being traced
        logic need_r2;    // region one has ended, region two setup is due
        logic slot_free;  // output register can take a new group
    } mer_status_t;

endpackage

// ===== hdl/mer_dp.sv =====
// ----------------------------------------------------------------------------
// mer_dp
// Datapath: held ellipse parameters, incremental decision terms, one shared
// registered multiplier for setup products, and the output register.
// ----------------------------------------------------------------------------
module mer_dp #(
    parameter int AXIS_BITS  = 11,
    parameter int COORD_BITS = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mer_pkg::mer_cmd_t               cmd,
    output mer_pkg::mer_status_t            status,
    input  logic [COORD_BITS-1:0]           center_x,
    input  logic [COORD_BITS-1:0]           center_y,
    input  logic [AXIS_BITS-1:0]            semi_x,
    input  logic [AXIS_BITS-1:0]            semi_y,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y (14 bits each)
    output logic [mer_pkg::OUT_TDATA_W-1:0] m_tdata,
    // points_valid
    output logic                            m_tuser,
    output logic                            m_tlast
);
    import mer_pkg::*;

    localparam int X_W   = AXIS_BITS + 2;
    localparam int Y_W   = AXIS_BITS + 2;
    localparam int SQ_W  = 2 * AXIS_BITS;
    localparam int MW    = 2 * AXIS_BITS + 3;
    localparam int PW    = 2 * MW;
    localparam int DEC_W = (4 * AXIS_BITS + 6 < 64) ? 4 * AXIS_BITS + 6 : 64;
    localparam int T_W   = (4 * AXIS_BITS + 8 < 64) ? 4 * AXIS_BITS + 8 : 64;
    localparam logic signed [Y_W-1:0] Y_ONE = Y_W'(1);

    // Held parameters and setup products
    logic [COORD_BITS-1:0] held_cx_reg, held_cx_next;
    logic [COORD_BITS-1:0] held_cy_reg, held_cy_next;
    logic [AXIS_BITS-1:0]  held_a_reg, held_a_next;
    logic [AXIS_BITS-1:0]  held_b_reg, held_b_next;
    logic [SQ_W-1:0]       a2_reg, a2_next;
    logic [SQ_W-1:0]       b2_reg, b2_next;
    logic [PW-1:0]         prod_reg, prod_next;
    logic [T_W-1:0]        acc_reg, acc_next;

    // Tracing state
    logic [DEC_W-1:0]        dec_reg, dec_next;
    logic [DEC_W-1:0]        two_b2x_reg, two_b2x_next;
    logic [DEC_W-1:0]        two_a2y_reg, two_a2y_next;
    logic [X_W-1:0]          x_reg, x_next;
    logic signed [Y_W-1:0]   y_reg, y_next;
    logic                    r2_reg, r2_next;
    logic                    diag_reg, diag_next;
    logic                    active_reg, active_next;

    // Pending group and output register
    logic [OUT_W-1:0] pend_px_reg, pend_px_next;
    logic [OUT_W-1:0] pend_mx_reg, pend_mx_next;
    logic [OUT_W-1:0] pend_py_reg, pend_py_next;
    logic [OUT_W-1:0] pend_my_reg, pend_my_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [OUT_W-1:0] out_px_reg, out_px_next;
    logic [OUT_W-1:0] out_mx_reg, out_mx_next;
    logic [OUT_W-1:0] out_py_reg, out_py_next;
    logic [OUT_W-1:0] out_my_reg, out_my_next;
    logic             out_pv_reg, out_pv_next;
    logic             out_last_reg, out_last_next;
    logic             out_valid_reg, out_valid_next;

    // Combinational helpers
    logic [MW-1:0]        mul_a;
    logic [MW-1:0]        mul_b;
    logic [PW-1:0]        mul_p;
    logic                 dec_neg;
    logic                 dec_zero;
    logic                 diag;
    logic                 done;
    logic                 x_lt;
    logic [DEC_W-1:0]     two_b2;
    logic [DEC_W-1:0]     two_a2;
    logic signed [Y_W-1:0] ym1;
    logic [T_W-1:0]       t_full;
    logic [T_W-1:0]       t_adj;
    logic [T_W-1:0]       t_div;
    logic [OUT_W-1:0]     cx14;
    logic [OUT_W-1:0]     cy14;
    logic [OUT_W-1:0]     x14;
    logic [OUT_W-1:0]     y14;

    // Decision flags and step constants
    assign dec_neg  = dec_reg[DEC_W-1];
    assign dec_zero = (dec_reg == '0);
    assign diag     = r2_reg ? (dec_neg | dec_zero) : ~dec_neg;
    assign done     = r2_reg & y_reg[Y_W-1];
    assign x_lt     = (two_b2x_reg < two_a2y_reg);
    assign two_b2   = DEC_W'({b2_reg, 1'b0});
    assign two_a2   = DEC_W'({a2_reg, 1'b0});
    assign ym1      = (y_reg > 0) ? (y_reg - Y_ONE) : (Y_ONE - y_reg);

    // Region two start value: exact quarter, rounded toward zero
    assign t_full = acc_reg - (T_W'(prod_reg) << 2);
    assign t_adj  = t_full + (t_full[T_W-1] ? T_W'(3) : T_W'(0));
    assign t_div  = {{2{t_adj[T_W-1]}}, t_adj[T_W-1:2]};

    // Point coordinates, modulo 2^14
    assign cx14 = OUT_W'(held_cx_reg);
    assign cy14 = OUT_W'(held_cy_reg);
    assign x14  = OUT_W'(x_reg);
    assign y14  = OUT_W'(y_reg);

    // Shared multiplier operand select
    always_comb
    begin
        case (cmd.op)
            OP_SQ_A:
            begin
                mul_a = MW'(held_a_reg);
                mul_b = MW'(held_a_reg);
            end
            OP_SQ_B:
            begin
                mul_a = MW'(held_b_reg);
                mul_b = MW'(held_b_reg);
            end
            OP_MUL_A2B:
            begin
                mul_a = MW'(a2_reg);
                mul_b = MW'(held_b_reg);
            end
            OP_T_P1:
            begin
                mul_a = MW'({x_reg, 1'b1});
                mul_b = MW'(held_b_reg);
            end
            OP_SQUARE:
            begin
                mul_a = MW'(prod_reg);
                mul_b = MW'(prod_reg);
            end
            OP_T_Q1:
            begin
                mul_a = MW'(unsigned'(ym1));
                mul_b = MW'(held_a_reg);
            end
            OP_T_R1:
            begin
                mul_a = MW'(held_a_reg);
                mul_b = MW'(held_b_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // Next-state logic of the datapath registers
    always_comb
    begin
        held_cx_next    = held_cx_reg;
        held_cy_next    = held_cy_reg;
        held_a_next     = held_a_reg;
        held_b_next     = held_b_reg;
        a2_next         = a2_reg;
        b2_next         = b2_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        dec_next        = dec_reg;
        two_b2x_next    = two_b2x_reg;
        two_a2y_next    = two_a2y_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        r2_next         = r2_reg;
        diag_next       = diag_reg;
        active_next     = active_reg;
        pend_px_next    = pend_px_reg;
        pend_mx_next    = pend_mx_reg;
        pend_py_next    = pend_py_reg;
        pend_my_next    = pend_my_reg;
        pend_valid_next = pend_valid_reg;
        out_px_next     = out_px_reg;
        out_mx_next     = out_mx_reg;
        out_py_next     = out_py_reg;
        out_my_next     = out_my_reg;
        out_pv_next     = out_pv_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg & ~m_tready;

        case (cmd.op)
            OP_LOAD:
            begin
                held_cx_next = center_x;
                held_cy_next = center_y;
                held_a_next  = semi_x;
                held_b_next  = semi_y;
                x_next       = '0;
                y_next       = Y_W'(semi_y);
                r2_next      = 1'b0;
                active_next  = 1'b1;
            end
            OP_SQ_A:
            begin
                prod_next = mul_p;
            end
            OP_SQ_B:
            begin
                a2_next   = SQ_W'(prod_reg);
                prod_next = mul_p;
            end
            OP_MUL_A2B:
            begin
                b2_next   = SQ_W'(prod_reg);
                prod_next = mul_p;
            end
            OP_INIT_DEC:
            begin
                // B^2 - A^2*B + floor(A^2/4), y = B so 2*A^2*y = 2*A^2*B
                dec_next     = DEC_W'(b2_reg) + DEC_W'(a2_reg >> 2) - DEC_W'(prod_reg);
                two_a2y_next = DEC_W'(prod_reg) << 1;
                two_b2x_next = '0;
            end
            OP_CAPTURE:
            begin
                pend_px_next    = active_reg ? (cx14 + x14) : '0;
                pend_mx_next    = active_reg ? (cx14 - x14) : '0;
                pend_py_next    = active_reg ? (cy14 + y14) : '0;
                pend_my_next    = active_reg ? (cy14 - y14) : '0;
                pend_valid_next = active_reg;
            end
            OP_U1:
            begin
                // Move x and/or y, and add the constant term of the update
                diag_next = diag;
                dec_next  = dec_reg + (r2_reg ? DEC_W'(a2_reg) : DEC_W'(b2_reg));
                if (!r2_reg || diag)
                begin
                    x_next       = x_reg + X_W'(1);
                    two_b2x_next = two_b2x_reg + two_b2;
                end
                if (r2_reg || diag)
                begin
                    y_next       = y_reg - Y_ONE;
                    two_a2y_next = two_a2y_reg - two_a2;
                end
            end
            OP_U2:
            begin
                if (!r2_reg || diag_reg)
                begin
                    dec_next = dec_reg + two_b2x_reg;
                end
            end
            OP_U3:
            begin
                if (r2_reg || diag_reg)
                begin
                    dec_next = dec_reg - two_a2y_reg;
                end
            end
            OP_T_P1, OP_SQUARE:
            begin
                prod_next = mul_p;
            end
            OP_T_Q1:
            begin
                acc_next  = T_W'(prod_reg);
                prod_next = mul_p;
            end
            OP_T_R1:
            begin
                acc_next  = acc_reg + (T_W'(prod_reg) << 2);
                prod_next = mul_p;
            end
            OP_T_FIN:
            begin
                dec_next = DEC_W'(t_div);
                r2_next  = 1'b1;
            end
            OP_EMIT:
            begin
                out_px_next    = pend_px_reg;
                out_mx_next    = pend_mx_reg;
                out_py_next    = pend_py_reg;
                out_my_next    = pend_my_reg;
                out_pv_next    = pend_valid_reg;
                out_last_next  = pend_valid_reg & done;
                out_valid_next = 1'b1;
                if (pend_valid_reg && done)
                begin
                    active_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        held_cx_reg    <= held_cx_next;
        held_cy_reg    <= held_cy_next;
        held_a_reg     <= held_a_next;
        held_b_reg     <= held_b_next;
        a2_reg         <= a2_next;
        b2_reg         <= b2_next;
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        dec_reg        <= dec_next;
        two_b2x_reg    <= two_b2x_next;
        two_a2y_reg    <= two_a2y_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        r2_reg         <= r2_next;
        diag_reg       <= diag_next;
        pend_px_reg    <= pend_px_next;
        pend_mx_reg    <= pend_mx_next;
        pend_py_reg    <= pend_py_next;
        pend_my_reg    <= pend_my_next;
        pend_valid_reg <= pend_valid_next;
        out_px_reg     <= out_px_next;
        out_mx_reg     <= out_mx_next;
        out_py_reg     <= out_py_next;
        out_my_reg     <= out_my_next;
        out_pv_reg     <= out_pv_next;
        out_last_reg   <= out_last_next;
    end

    // Status back to the controller
    always_comb
    begin
        status.active    = active_reg;
        status.need_r2   = ~r2_reg & ~x_lt;
        status.slot_free = ~out_valid_reg | m_tready;
    end

    // Output channel
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_pv_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_my_reg, out_mx_reg, out_py_reg, out_px_reg,
                       out_py_reg, out_mx_reg, out_my_reg, out_px_reg};

endmodule

// ===== hdl/mer_ctrl.sv =====
// ----------------------------------------------------------------------------
// mer_ctrl
// Controller: sequences setup products, the per-step decision update and
// the region two setup, and hands finished groups to the output register.
// ----------------------------------------------------------------------------
module mer_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_func,
    output mer_pkg::mer_cmd_t    cmd,
    input  mer_pkg::mer_status_t status
);
    import mer_pkg::*;

    mer_state_t state_reg, state_next;
    logic       is_step_reg, is_step_next;

    // Next state
    always_comb
    begin
        state_next   = state_reg;
        is_step_next = is_step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_func == FUNC_START)
                    begin
                        state_next   = ST_SQ_A;
                        is_step_next = 1'b0;
                    end
                    else
                    begin
                        state_next   = status.active ? ST_U1 : ST_FINISH;
                        is_step_next = 1'b1;
                    end
                end
            end
            ST_SQ_A:     state_next = ST_SQ_B;
            ST_SQ_B:     state_next = ST_MUL_A2B;
            ST_MUL_A2B:  state_next = ST_INIT_DEC;
            ST_INIT_DEC: state_next = ST_CHECK;
            ST_U1:       state_next = ST_U2;
            ST_U2:       state_next = ST_U3;
            ST_U3:       state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (status.need_r2)
                begin
                    state_next = ST_T_P1;
                end
                else
                begin
                    state_next = is_step_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_T_P1:     state_next = ST_T_P2;
            ST_T_P2:     state_next = ST_T_Q1;
            ST_T_Q1:     state_next = ST_T_Q2;
            ST_T_Q2:     state_next = ST_T_R1;
            ST_T_R1:     state_next = ST_T_R2;
            ST_T_R2:     state_next = ST_T_FIN;
            ST_T_FIN:    state_next = is_step_reg ? ST_FINISH : ST_IDLE;
            ST_FINISH:
            begin
                if (status.slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        s_tready = 1'b0;
        cmd.op   = OP_NOP;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op = (s_func == FUNC_START) ? OP_LOAD : OP_CAPTURE;
                end
            end
            ST_SQ_A:     cmd.op = OP_SQ_A;
            ST_SQ_B:     cmd.op = OP_SQ_B;
            ST_MUL_A2B:  cmd.op = OP_MUL_A2B;
            ST_INIT_DEC: cmd.op = OP_INIT_DEC;
            ST_U1:       cmd.op = OP_U1;
            ST_U2:       cmd.op = OP_U2;
            ST_U3:       cmd.op = OP_U3;
            ST_T_P1:     cmd.op = OP_T_P1;
            ST_T_P2:     cmd.op = OP_SQUARE;
            ST_T_Q1:     cmd.op = OP_T_Q1;
            ST_T_Q2:     cmd.op = OP_SQUARE;
            ST_T_R1:     cmd.op = OP_T_R1;
            ST_T_R2:     cmd.op = OP_SQUARE;
            ST_T_FIN:    cmd.op = OP_T_FIN;
            ST_FINISH:   cmd.op = status.slot_free ? OP_EMIT : OP_NOP;
            default:     cmd.op = OP_NOP;
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            is_step_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            is_step_reg <= is_step_next;
        end
    end

endmodule

// ===== hdl/midpoint_ellipse_rasterizer.sv =====
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// Sequencing: a step item runs the decision update states U1, U2, U3 and the check,
//   plus the region two setup on the step where region two begins, then hands its
//   point group to the output register; an idle step goes straight to the hand-off.
// Throughput: one item at a time; a start runs the setup products and the check (and
//   region two setup if it begins at once); a held group waiting on m_tready holds off
//   the next item. The shared setup multiplier and one-add-per-cycle update set the pace.
// Reset: asynchronous; the block comes up idle with no ellipse active.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer #(
    parameter int AXIS_BITS  = 11,
    parameter int COORD_BITS = 12,
    localparam int IN_W       = 2 * COORD_BITS + 2 * AXIS_BITS,
    localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // center_x, center_y, semi_x, semi_y, zero fill
    input  logic [IN_TDATA_W-1:0]           s_tdata,
    // func
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y (14 bits each)
    output logic [mer_pkg::OUT_TDATA_W-1:0] m_tdata,
    // points_valid
    output logic                            m_tuser,
    // last_group
    output logic                            m_tlast
);
    import mer_pkg::*;

    mer_cmd_t              cmd;
    mer_status_t           status;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [AXIS_BITS-1:0]  semi_x;
    logic [AXIS_BITS-1:0]  semi_y;

    // Unpack the input transfer
    assign center_x = s_tdata[COORD_BITS-1:0];
    assign center_y = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign semi_x   = s_tdata[2*COORD_BITS+AXIS_BITS-1:2*COORD_BITS];
    assign semi_y   = s_tdata[2*COORD_BITS+2*AXIS_BITS-1:2*COORD_BITS+AXIS_BITS];

    mer_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_func   (s_tuser),
        .cmd      (cmd),
        .status   (status)
    );

    mer_dp #(
        .AXIS_BITS  (AXIS_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .center_x (center_x),
        .center_y (center_y),
        .semi_x   (semi_x),
        .semi_y   (semi_y),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== test/midpoint_ellipse_rasterizer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_test
// Streams start and step transfers into the rasterizer. A behavioral model of
// the two-region midpoint ellipse trace predicts each point group. A short
// directed table covers the extremes, idle steps and degenerate axes. Random
// ellipse traces with random idling on both sides follow.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_test;

    localparam int IN_TDATA_W   = ((2 * 12 + 2 * 11 + 7) / 8) * 8;
    localparam int OUT_W        = mer_pkg::OUT_W;
    localparam int OUT_TDATA_W  = mer_pkg::OUT_TDATA_W;
    localparam int RANDOM_ITEMS = 1000;
    localparam int QUIET_ITEMS  = 100;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 16;
    localparam int PRINT_LIMIT  = 200;

    // One point group as it leaves the block
    typedef struct packed {
        logic [OUT_TDATA_W-1:0] pts;
        logic                   pv;
        logic                   lg;
    } point_group_t;

    // One input transfer; typed rows carry their own expected group
    typedef struct packed {
        logic         func;
        logic [11:0]  cx;
        logic [11:0]  cy;
        logic [10:0]  a;
        logic [10:0]  b;
        bit           typed;
        point_group_t want;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // center_x, center_y, semi_x, semi_y, zero fill
    logic                   s_tuser;   // func
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
    logic                   m_tuser;   // points_valid
    logic                   m_tlast;   // last_group

    // Model state of the ellipse trace
    int          trace_x = 0;
    int          trace_y = 0;
    logic [63:0] dvar = '0;
    bit          in_r2 = 0;
    bit          tracing = 0;
    logic [11:0] org_x = '0;
    logic [11:0] org_y = '0;
    logic [10:0] rad_a = '0;
    logic [10:0] rad_b = '0;

    point_group_t pending_groups[$];
    stim_row_t    stim_table[$];
    int           mismatch_count = 0;
    int           idle_cycles = 0;
    bit           quiet = 0;
    bit           tx_calm = 0;

    midpoint_ellipse_rasterizer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 clk = ~clk;

    // Switch to region two when the slope passes -1; true once y drops below 0
    function automatic bit settle_region();
        logic [63:0] a2, b2, xv, yv, ym1, t;
        a2 = 64'(rad_a) * 64'(rad_a);
        b2 = 64'(rad_b) * 64'(rad_b);
        if (!in_r2)
        begin
            xv = (trace_x < 0) ? 64'd0 : 64'(trace_x);
            yv = (trace_y < 0) ? 64'd0 : 64'(trace_y);
            if (!(xv * b2 < yv * a2))
            begin
                ym1 = (trace_y <= 0) ? 64'(1 - trace_y) : 64'(trace_y - 1);
                t = (4 * xv * xv + 4 * xv + 1) * b2 + 4 * ym1 * ym1 * a2 - 4 * a2 * b2;
                // divide by four, rounding toward zero
                dvar = t[63] ? -((-t) >> 2) : (t >> 2);
                in_r2 = 1;
            end
        end
        return in_r2 && (trace_y < 0);
    endfunction

    function automatic logic [OUT_W-1:0] wrap_coord(logic [11:0] c, int off);
        return OUT_W'(int'(c) + off);
    endfunction

    // Apply one accepted transfer to the model; returns 1 if it yields a group
    function automatic bit trace_ellipse_item(input stim_row_t r, output point_group_t grp);
        logic [63:0] a2, b2, xs, ys;
        grp = '0;
        if (r.func == mer_pkg::FUNC_START)
        begin
            org_x = r.cx;
            org_y = r.cy;
            rad_a = r.a;
            rad_b = r.b;
            a2 = 64'(rad_a) * 64'(rad_a);
            b2 = 64'(rad_b) * 64'(rad_b);
            trace_x = 0;
            trace_y = int'(rad_b);
            dvar = b2 - a2 * 64'(rad_b) + (a2 >> 2);
            in_r2 = 0;
            tracing = 1;
            void'(settle_region());
            return 0;
        end
        if (!tracing)
            return 1;

        grp.pts = {wrap_coord(org_y, -trace_y), wrap_coord(org_x, -trace_x),
                   wrap_coord(org_y, trace_y),  wrap_coord(org_x, trace_x),
                   wrap_coord(org_y, trace_y),  wrap_coord(org_x, -trace_x),
                   wrap_coord(org_y, -trace_y), wrap_coord(org_x, trace_x)};
        grp.pv = 1;

        a2 = 64'(rad_a) * 64'(rad_a);
        b2 = 64'(rad_b) * 64'(rad_b);
        if (!in_r2)
        begin
            // region one: x always advances
            trace_x++;
            xs = longint'(trace_x);
            if (dvar[63])
                dvar = dvar + 2 * b2 * xs + b2;
            else
            begin
                trace_y--;
                ys = longint'(trace_y);
                dvar = dvar + 2 * b2 * xs + b2 - 2 * a2 * ys;
            end
        end
        else
        begin
            // region two: y always falls
            trace_y--;
            ys = longint'(trace_y);
            if (!dvar[63] && dvar != 0)
                dvar = dvar + a2 - 2 * a2 * ys;
            else
            begin
                trace_x++;
                xs = longint'(trace_x);
                dvar = dvar + 2 * b2 * xs - 2 * a2 * ys + a2;
            end
        end

        if (settle_region())
        begin
            tracing = 0;
            grp.lg = 1;
        end
        return 1;
    endfunction

    function automatic stim_row_t make_row(logic func, logic [11:0] cx, logic [11:0] cy,
                                           logic [10:0] a, logic [10:0] b,
                                           bit typed, point_group_t want);
        stim_row_t r;
        r.func  = func;
        r.cx    = cx;
        r.cy    = cy;
        r.a     = a;
        r.b     = b;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    // Append one row to the directed table
    task automatic add_row(input stim_row_t r);
        stim_table.insert(stim_table.size(), r);
    endtask

    // Drive one transfer, wait for it to be taken, then record its expectation
    task automatic send_item(input stim_row_t r);
        point_group_t grp;
        int           gap;
        gap = 0;
        if ($urandom_range(0, 49) == 0)
            tx_calm = !tx_calm;
        if (!quiet && !tx_calm && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 13);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.func;
        s_tdata  <= {2'b00, r.b, r.a, r.cy, r.cx};
        do
            @(posedge clk);
        while (!s_tready);
        if (trace_ellipse_item(r, grp))
            pending_groups.insert(pending_groups.size(), r.typed ? r.want : grp);
    endtask

    // Hold the sender off until every outstanding group has come out
    task automatic drain_pause();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_groups.size() != 0);
    endtask

    // Output checker
    always @(posedge clk)
    begin
        point_group_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_groups.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= PRINT_LIMIT)
                    $display("%0t: unexpected group, expected none, actual %h pv %b last %b",
                             $time, m_tdata, m_tuser, m_tlast);
            end
            else
            begin
                want = pending_groups.pop_front();
                for (int f = 0; f < 2 * mer_pkg::N_POINTS; f++)
                begin
                    if (m_tdata[f*OUT_W +: OUT_W] !== want.pts[f*OUT_W +: OUT_W])
                    begin
                        mismatch_count++;
                        if (mismatch_count <= PRINT_LIMIT)
                            $display("%0t: p%0d_%s expected %0d actual %0d", $time, f / 2,
                                     (f % 2) ? "y" : "x",
                                     $signed(want.pts[f*OUT_W +: OUT_W]),
                                     $signed(m_tdata[f*OUT_W +: OUT_W]));
                    end
                end
                if (m_tuser !== want.pv)
                begin
                    mismatch_count++;
                    if (mismatch_count <= PRINT_LIMIT)
                        $display("%0t: points_valid expected %b actual %b",
                                 $time, want.pv, m_tuser);
                end
                if (m_tlast !== want.lg)
                begin
                    mismatch_count++;
                    if (mismatch_count <= PRINT_LIMIT)
                        $display("%0t: last_group expected %b actual %b",
                                 $time, want.lg, m_tlast);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Receiver backpressure in random bursts
    initial
    begin
        int stall_left;
        bit calm;
        stall_left = 0;
        calm = 0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 199) == 0)
                calm = !calm;
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!quiet && !calm && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 12);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Stimulus
    initial
    begin
        stim_row_t    r;
        stim_row_t    step_row;
        point_group_t none_grp;
        int           random_items;
        int           pick;
        int           lim;
        int           steps_cap;
        int           n;

        clk      = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;

        none_grp = '0;
        step_row = make_row(mer_pkg::FUNC_STEP, 12'd0, 12'd0, 11'd0, 11'd0, 0, none_grp);

        // idle steps, single-group ellipses at the corners, vertical line,
        // largest ellipse cut short by a new start, then a small full trace
        add_row(make_row(mer_pkg::FUNC_STEP, 12'd0, 12'd0, 11'd0, 11'd0,
                         1, none_grp));
        add_row(make_row(mer_pkg::FUNC_START, 12'd4095, 12'd4095, 11'd2047,
                         11'd0, 0, none_grp));
        add_row(make_row(mer_pkg::FUNC_STEP, 12'd0, 12'd0, 11'd0, 11'd0,
                         1, '{pts: {8{14'd4095}}, pv: 1'b1, lg: 1'b1}));
        add_row(make_row(mer_pkg::FUNC_STEP, 12'd4095, 12'd4095, 11'd2047,
                         11'd2047, 1, none_grp));
        add_row(make_row(mer_pkg::FUNC_START, 12'd0, 12'd0, 11'd0, 11'd0,
                         0, none_grp));
        add_row(make_row(mer_pkg::FUNC_STEP, 12'd0, 12'd0, 11'd0, 11'd0,
                         1, '{pts: {8{14'd0}}, pv: 1'b1, lg: 1'b1}));
        add_row(make_row(mer_pkg::FUNC_START, 12'd0, 12'd0, 11'd0, 11'd3,
                         0, none_grp));
        repeat (5) add_row(step_row);
        add_row(make_row(mer_pkg::FUNC_START, 12'd4095, 12'd0, 11'd2047,
                         11'd2047, 0, none_grp));
        repeat (3) add_row(step_row);
        add_row(make_row(mer_pkg::FUNC_START, 12'd123, 12'd2345, 11'd5, 11'd3,
                         0, none_grp));
        repeat (8) add_row(step_row);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
            send_item(stim_table[i]);
        drain_pause();

        // Random traces: mostly complete ellipses, some aborted, some bare steps
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            quiet = (random_items >= RANDOM_ITEMS - QUIET_ITEMS);
            pick = $urandom_range(0, 99);
            if (pick < 3 && !quiet)
                drain_pause();
            if (pick < 8)
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                begin
                    send_item(step_row);
                    random_items++;
                end
            end
            else
            begin
                pick = $urandom_range(0, 99);
                lim = (pick < 80) ? 12 : (pick < 92) ? 40 : 2047;
                r = make_row(mer_pkg::FUNC_START, 12'($urandom_range(0, 4095)),
                             12'($urandom_range(0, 4095)), 11'($urandom_range(0, lim)),
                             11'($urandom_range(0, lim)), 0, none_grp);
                send_item(r);
                random_items++;
                steps_cap = (lim == 2047) ? $urandom_range(1, 20) : 100000;
                if ($urandom_range(0, 19) == 0)
                    steps_cap = $urandom_range(0, 5);
                n = 0;
                while (tracing && n < steps_cap)
                begin
                    send_item(step_row);
                    n++;
                    random_items++;
                end
            end
        end

        // Wind down
        s_tvalid <= 1'b0;
        while (pending_groups.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_groups.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/mer_pkg.sv
hdl/mer_dp.sv
hdl/mer_ctrl.sv
hdl/midpoint_ellipse_rasterizer.sv
test/midpoint_ellipse_rasterizer_test.sv
